[design/lbg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_pkg
// Types, constants and microprogram for the binary GCD / LCM unit.
// ----------------------------------------------------------------------------
package lbg_pkg;

   localparam int LBG_OPND_W    = 32;
   localparam int LBG_LCM_W     = 64;
   localparam int LBG_WIDTH_DEF = 32;
   localparam int LBG_PC_W      = 4;

   typedef logic [LBG_PC_W-1:0] lbg_addr_type;

   localparam lbg_addr_type LBG_PC_START   = 4'd0;
   localparam lbg_addr_type LBG_PC_TWOS    = 4'd1;
   localparam lbg_addr_type LBG_PC_STRIP_X = 4'd2;
   localparam lbg_addr_type LBG_PC_STRIP_Y = 4'd3;
   localparam lbg_addr_type LBG_PC_SUB     = 4'd4;
   localparam lbg_addr_type LBG_PC_RESCALE = 4'd5;
   localparam lbg_addr_type LBG_PC_DIVINIT = 4'd6;
   localparam lbg_addr_type LBG_PC_DIV     = 4'd7;
   localparam lbg_addr_type LBG_PC_MUL     = 4'd8;
   localparam lbg_addr_type LBG_PC_END     = 4'd9;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_SHIFT_BOTH,
      OP_SHIFT_X,
      OP_SHIFT_Y,
      OP_SUB,
      OP_SHIFT_G,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL
   } lbg_op_type;

   typedef enum logic [2:0] {
      CND_NONE,
      CND_ANY_ZERO,
      CND_EITHER_ODD,
      CND_X_ODD,
      CND_Y_ODD,
      CND_X_NE_Y,
      CND_TWOS_ZERO,
      CND_CNT_DONE
   } lbg_cond_type;

   // advance: run op, step on; loop: run op and hold until cond, then go to target
   // branch: run op, jump to target on cond; end: retire result
   typedef enum logic [1:0] {
      MD_ADVANCE,
      MD_LOOP,
      MD_BRANCH,
      MD_END
   } lbg_mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } lbg_state_type;

   typedef struct packed {
      lbg_mode_type mode;
      lbg_op_type   op;
      lbg_cond_type cond;
      lbg_addr_type target;
   } lbg_ctl_type;

   typedef struct packed {
      logic       load;
      logic       exec;
      lbg_op_type op;
   } lbg_cmd_type;

   typedef struct packed {
      logic any_zero;
      logic both_zero;
      logic either_odd;
      logic x_odd;
      logic y_odd;
      logic x_ne_y;
      logic twos_zero;
      logic cnt_done;
   } lbg_stat_type;

   function automatic lbg_ctl_type lbg_rom(input lbg_addr_type pc);
      lbg_ctl_type w;
      unique case (pc)
         LBG_PC_START:   w = '{MD_BRANCH,  OP_NOP,        CND_ANY_ZERO,   LBG_PC_END};
         LBG_PC_TWOS:    w = '{MD_LOOP,    OP_SHIFT_BOTH, CND_EITHER_ODD, LBG_PC_STRIP_X};
         LBG_PC_STRIP_X: w = '{MD_LOOP,    OP_SHIFT_X,    CND_X_ODD,      LBG_PC_STRIP_Y};
         LBG_PC_STRIP_Y: w = '{MD_LOOP,    OP_SHIFT_Y,    CND_Y_ODD,      LBG_PC_SUB};
         LBG_PC_SUB:     w = '{MD_BRANCH,  OP_SUB,        CND_X_NE_Y,     LBG_PC_STRIP_Y};
         LBG_PC_RESCALE: w = '{MD_LOOP,    OP_SHIFT_G,    CND_TWOS_ZERO,  LBG_PC_DIVINIT};
         LBG_PC_DIVINIT: w = '{MD_ADVANCE, OP_DIV_INIT,   CND_NONE,       LBG_PC_DIV};
         LBG_PC_DIV:     w = '{MD_LOOP,    OP_DIV_STEP,   CND_CNT_DONE,   LBG_PC_MUL};
         LBG_PC_MUL:     w = '{MD_ADVANCE, OP_MUL,        CND_NONE,       LBG_PC_END};
         default:        w = '{MD_END,     OP_NOP,        CND_NONE,       LBG_PC_END};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[design/lbg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_req_if / lbg_rsp_if
// Valid/ready channels carrying operand pairs and GCD/LCM results.
// ----------------------------------------------------------------------------
interface lbg_req_if
   import lbg_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [LBG_OPND_W-1:0] operand_a;
   logic [LBG_OPND_W-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface lbg_rsp_if
   import lbg_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [LBG_OPND_W-1:0] gcd_value;
   logic [LBG_LCM_W-1:0]  lcm_value;
   logic                  both_zero;

   modport source (output valid, output gcd_value, output lcm_value, output both_zero,
                   input ready);
   modport sink   (input valid, input gcd_value, input lcm_value, input both_zero,
                   output ready);
endinterface
`default_nettype wire

[design/lbg_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_datapath
// Shift/subtract registers, restoring divider and multiplier driven by the
// microprogram one operation per cycle, except in loop exit tests and while a result waits to retire.
// ----------------------------------------------------------------------------
module lbg_datapath
   import lbg_pkg::*;
#(
   parameter int WIDTH = LBG_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic [WIDTH-1:0]      operand_a,
   input  logic [WIDTH-1:0]      operand_b,
   input  lbg_cmd_type           cmd,
   output lbg_stat_type          stat,
   output logic [WIDTH-1:0]      gcd,
   output logic [2*WIDTH-1:0]    lcm
);

   localparam int TW_W  = $clog2(WIDTH);
   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0]   a_ff, a_in, b_ff, b_in, x_ff, x_in, y_ff, y_in;
   logic [WIDTH-1:0]   q_ff, q_in, r_ff, r_in;
   logic [TW_W-1:0]    twos_ff, twos_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [2*WIDTH-1:0] prod_ff, prod_in;
   logic [WIDTH:0]     rem_sh, rem_sub;
   logic               rem_ge;
   logic [2*WIDTH-1:0] mul;

   assign rem_sh  = {r_ff, q_ff[WIDTH-1]};
   assign rem_sub = rem_sh - {1'b0, x_ff};
   assign rem_ge  = rem_sh >= {1'b0, x_ff};
   assign mul     = q_ff * b_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      twos_in = twos_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         a_in    = operand_a;
         b_in    = operand_b;
         x_in    = operand_a;
         y_in    = operand_b;
         twos_in = '0;
         prod_in = '0;
      end else if (cmd.exec) begin
         unique case (cmd.op)
            OP_NOP: ;
            OP_SHIFT_BOTH: begin
               x_in    = x_ff >> 1;
               y_in    = y_ff >> 1;
               twos_in = twos_ff + 1'b1;
            end
            OP_SHIFT_X: x_in = x_ff >> 1;
            OP_SHIFT_Y: y_in = y_ff >> 1;
            OP_SUB: begin
               if (x_ff > y_ff) begin
                  x_in = y_ff;
                  y_in = x_ff - y_ff;
               end else begin
                  y_in = y_ff - x_ff;
               end
            end
            OP_SHIFT_G: begin
               x_in    = x_ff << 1;
               twos_in = twos_ff - 1'b1;
            end
            OP_DIV_INIT: begin
               q_in   = a_ff;
               r_in   = '0;
               cnt_in = '0;
            end
            OP_DIV_STEP: begin
               r_in   = rem_ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
               q_in   = {q_ff[WIDTH-2:0], rem_ge};
               cnt_in = cnt_ff + 1'b1;
            end
            OP_MUL: prod_in = mul;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      twos_ff <= twos_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      stat.any_zero   = (a_ff == '0) || (b_ff == '0);
      stat.both_zero  = (a_ff == '0) && (b_ff == '0);
      stat.either_odd = x_ff[0] | y_ff[0];
      stat.x_odd      = x_ff[0];
      stat.y_odd      = y_ff[0];
      stat.x_ne_y     = x_ff != y_ff;
      stat.twos_zero  = twos_ff == '0;
      stat.cnt_done   = cnt_ff == CNT_W'(WIDTH);
   end

   // with one operand zero the GCD is the other operand
   assign gcd = stat.any_zero ? (a_ff | b_ff) : x_ff;
   assign lcm = stat.any_zero ? '0 : prod_ff;

endmodule
`default_nettype wire

[design/lcm_binary_gcd_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_binary_gcd_unit
// GCD by Stein's binary algorithm and LCM as (a / gcd) * b, microcoded.
// ----------------------------------------------------------------------------
// One operand pair is processed at a time. When an operand is zero, a
// transaction only accepts the pair, tests for zero and retires. Otherwise its
// length is data dependent: it grows with each common factor of two, each
// further shift and each subtraction after the first. The microprogram sequencer
// issues one control word per cycle to a single shift/subtract datapath, except
// while a finished result waits for the output register, and each loop ends
// with an exit test in which no operation runs. The restoring divider runs after
// its set-up step and before the multiply step.
// The result sits in an output register, so the next operand pair is accepted
// while a finished result still waits to be taken.
// Operand bits at and above WIDTH are ignored.
module lcm_binary_gcd_unit
   import lbg_pkg::*;
#(
   parameter int WIDTH = LBG_WIDTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   lbg_req_if.sink  req_if,
   lbg_rsp_if.source rsp_if
);

   lbg_state_type         state_ff, state_in;
   lbg_addr_type          upc_ff, upc_in;
   lbg_ctl_type           ctl;
   lbg_cmd_type           cmd;
   lbg_stat_type          stat;
   logic                  cond_true;
   logic                  out_free;
   logic                  out_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LBG_OPND_W-1:0] gcd_ff;
   logic [LBG_LCM_W-1:0]  lcm_ff;
   logic                  zero_ff;
   logic [WIDTH-1:0]      gcd_w;
   logic [2*WIDTH-1:0]    lcm_w;

   assign ctl      = lbg_rom(upc_ff);
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = state_ff == ST_IDLE;

   always_comb begin
      case (ctl.cond)
         CND_NONE:       cond_true = 1'b0;
         CND_ANY_ZERO:   cond_true = stat.any_zero;
         CND_EITHER_ODD: cond_true = stat.either_odd;
         CND_X_ODD:      cond_true = stat.x_odd;
         CND_Y_ODD:      cond_true = stat.y_odd;
         CND_X_NE_Y:     cond_true = stat.x_ne_y;
         CND_TWOS_ZERO:  cond_true = stat.twos_zero;
         CND_CNT_DONE:   cond_true = stat.cnt_done;
         default:        cond_true = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      upc_in   = upc_ff;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      cmd.op   = ctl.op;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
               upc_in   = LBG_PC_START;
            end
         end
         ST_RUN: begin
            unique case (ctl.mode)
               MD_ADVANCE: begin
                  cmd.exec = 1'b1;
                  upc_in   = upc_ff + 1'b1;
               end
               MD_LOOP: begin
                  if (cond_true) begin
                     upc_in = ctl.target;
                  end else begin
                     cmd.exec = 1'b1;
                  end
               end
               MD_BRANCH: begin
                  cmd.exec = 1'b1;
                  upc_in   = cond_true ? ctl.target : upc_ff + 1'b1;
               end
               MD_END: begin
                  if (out_free) begin
                     out_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         upc_ff   <= LBG_PC_START;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
      end
   end

   lbg_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock     (clock),
      .operand_a (req_if.operand_a[WIDTH-1:0]),
      .operand_b (req_if.operand_b[WIDTH-1:0]),
      .cmd       (cmd),
      .stat      (stat),
      .gcd       (gcd_w),
      .lcm       (lcm_w)
   );

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload until the next result is retired
   always_ff @(posedge clock) begin
      if (out_load) begin
         gcd_ff  <= LBG_OPND_W'(gcd_w);
         lcm_ff  <= LBG_LCM_W'(lcm_w);
         zero_ff <= stat.both_zero;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.gcd_value = gcd_ff;
   assign rsp_if.lcm_value = lcm_ff;
   assign rsp_if.both_zero = zero_ff;

endmodule
`default_nettype wire

[design/lbg_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lbg_chk
// Port-level checks for the binary GCD / LCM unit, bound to the top level.
// ----------------------------------------------------------------------------
module lbg_chk
   import lbg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [LBG_OPND_W-1:0] gcd_value,
   input logic [LBG_LCM_W-1:0]  lcm_value,
   input logic                  both_zero
);

   // one transaction in flight: input closes once a pair is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a transaction is in progress");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && both_zero |-> gcd_value == '0 && lcm_value == '0)
      else $error("both-zero result with nonzero gcd or lcm");

   a_lcm_needs_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && lcm_value != '0 |-> gcd_value != '0 && !both_zero)
      else $error("nonzero lcm without a nonzero gcd");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(gcd_value) && $stable(lcm_value))
      else $error("stalled result changed or dropped");

endmodule

bind lcm_binary_gcd_unit lbg_chk u_lbg_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .gcd_value (rsp_if.gcd_value),
   .lcm_value (rsp_if.lcm_value),
   .both_zero (rsp_if.both_zero)
);
`default_nettype wire

[tb/lbg_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbg_result_checker
// Watches the operand and result channels of the binary GCD / LCM unit.
// Predicts GCD, double-width LCM and the both-zero flag for every accepted
// operand pair, then compares each accepted result, field by field, with the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module lbg_result_checker
   import lbg_pkg::*;
#(
   parameter int WIDTH = LBG_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   lbg_req_if   req_mon,
   lbg_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   results_checked
);

   localparam logic [63:0] OPND_MASK = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);

   typedef struct {
      logic [LBG_OPND_W-1:0] operand_a;
      logic [LBG_OPND_W-1:0] operand_b;
      logic [LBG_OPND_W-1:0] gcd_value;
      logic [LBG_LCM_W-1:0]  lcm_value;
      logic                  both_zero;
   } gcd_lcm_type;

   gcd_lcm_type gcd_lcm_due[$];

   function automatic gcd_lcm_type predict_gcd_lcm(input logic [LBG_OPND_W-1:0] a_in,
                                                    input logic [LBG_OPND_W-1:0] b_in);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] r;
      gcd_lcm_type res;
      a = {32'd0, a_in} & OPND_MASK;
      b = {32'd0, b_in} & OPND_MASK;
      res.operand_a = a_in;
      res.operand_b = b_in;
      res.gcd_value = '0;
      res.lcm_value = '0;
      res.both_zero = 1'b0;
      if (a == 0 && b == 0) begin
         res.both_zero = 1'b1;
      end else if (a == 0) begin
         res.gcd_value = b[LBG_OPND_W-1:0];
      end else if (b == 0) begin
         res.gcd_value = a[LBG_OPND_W-1:0];
      end else begin
         // Euclid gives the same divisor as the binary method
         x = a;
         y = b;
         while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
         end
         res.gcd_value = x[LBG_OPND_W-1:0];
         res.lcm_value = (a / x) * b;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      gcd_lcm_type due;
      int          errs;
      if (reset) begin
         gcd_lcm_due.delete();
         fail_count      <= 0;
         pending_count   <= 0;
         results_checked <= 0;
      end else begin
         errs = 0;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (gcd_lcm_due.size() == 0) begin
               $display("%0t: unexpected result: gcd %h lcm %h both_zero %b", $time,
                        rsp_mon.gcd_value, rsp_mon.lcm_value, rsp_mon.both_zero);
               errs = errs + 1;
            end else begin
               due = gcd_lcm_due.pop_front();
               if (rsp_mon.gcd_value !== due.gcd_value) begin
                  $display("%0t: gcd_value for a=%h b=%h: expected %h, actual %h", $time,
                           due.operand_a, due.operand_b, due.gcd_value, rsp_mon.gcd_value);
                  errs = errs + 1;
               end
               if (rsp_mon.lcm_value !== due.lcm_value) begin
                  $display("%0t: lcm_value for a=%h b=%h: expected %h, actual %h", $time,
                           due.operand_a, due.operand_b, due.lcm_value, rsp_mon.lcm_value);
                  errs = errs + 1;
               end
               if (rsp_mon.both_zero !== due.both_zero) begin
                  $display("%0t: both_zero for a=%h b=%h: expected %b, actual %b", $time,
                           due.operand_a, due.operand_b, due.both_zero, rsp_mon.both_zero);
                  errs = errs + 1;
               end
               results_checked <= results_checked + 1;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            gcd_lcm_due.push_back(predict_gcd_lcm(req_mon.operand_a, req_mon.operand_b));
         end
         fail_count    <= fail_count + errs;
         pending_count <= gcd_lcm_due.size();
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the binary GCD / LCM unit.
// Sends directed operand pairs (zeros, extremes, equal values, powers of two,
// large coprimes), then random pairs weighted towards shared factors, with
// random gaps on the operand side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
   import lbg_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_PAIRS = 1000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [LBG_OPND_W-1:0] OPND_MAX = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          fail_count;
   int          pending_count;
   int          results_checked;
   int          pairs_sent = 0;
   int          cycle_count = 0;
   int unsigned req_gap_max = 7;
   int unsigned rsp_stall_max = 7;

   always #4 clock = ~clock;

   lbg_req_if req ();
   lbg_rsp_if rsp ();

   lcm_binary_gcd_unit #(
      .WIDTH(LBG_WIDTH_DEF)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req),
      .rsp_if(rsp)
   );

   lbg_result_checker #(
      .WIDTH(LBG_WIDTH_DEF)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req),
      .rsp_mon        (rsp),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .results_checked(results_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped at cycle limit, %0d results outstanding", $time,
                  pending_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: stall a random number of cycles before each transaction
   initial begin
      int unsigned stall;
      rsp.ready <= 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp.valid && rsp.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_pair(input logic [LBG_OPND_W-1:0] a, input logic [LBG_OPND_W-1:0] b);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.operand_a <= a;
      req.operand_b <= b;
      @(posedge clock);
      while (!(req.valid && req.ready)) @(posedge clock);
      @(negedge clock);
      pairs_sent++;
   endtask

   task automatic send_random_pair();
      int unsigned           pick;
      int unsigned           g_bits;
      int unsigned           shift;
      logic [LBG_OPND_W-1:0] g;
      logic [LBG_OPND_W-1:0] x_mask;
      logic [LBG_OPND_W-1:0] a;
      logic [LBG_OPND_W-1:0] b;
      pick = $urandom_range(0, 99);
      a    = $urandom;
      b    = $urandom;
      if (pick < 30) begin
         // full-range values, mostly coprime
      end else if (pick < 60) begin
         g_bits = $urandom_range(1, 16);
         g      = $urandom_range(1, (1 << g_bits) - 1);
         x_mask = (32'd1 << (32 - g_bits)) - 32'd1;
         a      = g * ($urandom & x_mask);
         b      = g * ($urandom & x_mask);
      end else if (pick < 75) begin
         shift = $urandom_range(0, 31);
         a     = a << shift;
         shift = $urandom_range(0, 31);
         b     = b << shift;
      end else if (pick < 85) begin
         if ($urandom_range(0, 1) == 0) begin
            b = a;
         end else begin
            a = a >> $urandom_range(4, 28);
            b = a * $urandom_range(1, 15);
         end
      end else if (pick < 92) begin
         if ($urandom_range(0, 1) == 0) a = '0;
         else b = '0;
      end else if (pick < 95) begin
         a = '0;
         b = '0;
      end else begin
         a = ($urandom_range(0, 1) == 0) ? OPND_MAX : 32'd1;
         b = ($urandom_range(0, 1) == 0) ? OPND_MAX : OPND_MAX - $urandom_range(0, 3);
      end
      send_pair(a, b);
   endtask

   initial begin
      req.valid     <= 1'b0;
      req.operand_a <= '0;
      req.operand_b <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_pair(32'd0, 32'd0);
      send_pair(32'd0, 32'd12345);
      send_pair(32'd987654, 32'd0);
      send_pair(32'd0, OPND_MAX);
      send_pair(OPND_MAX, 32'd0);
      send_pair(32'd1, 32'd1);
      send_pair(OPND_MAX, OPND_MAX);
      send_pair(32'd1, OPND_MAX);
      send_pair(OPND_MAX, 32'd1);
      send_pair(OPND_MAX, OPND_MAX - 32'd1);
      send_pair(32'd77777, 32'd77777);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h4000_0000);
      send_pair(32'h8000_0000, 32'd3);
      send_pair(32'd4294967291, 32'd4294967279);
      send_pair(32'd12, 32'd18);
      send_pair(32'd18, 32'd12);
      send_pair(32'hAAAA_AAAA, 32'h5555_5555);
      send_pair(32'd2, 32'd3);
      send_pair(32'hFFFF_0000, 32'h0000_FFFF);

      // alternate stretches with idling and without
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i % 200 == 0) begin
            req_gap_max   = ((i / 200) % 2 == 1) ? 0 : 7;
            rsp_stall_max = ((i / 200) % 4 == 3) ? 0 : 7;
         end
         send_random_pair();
      end
      req.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d operand pairs and checked %0d results: zero operands, extremes,",
               pairs_sent, results_checked);
      $display("equal values, powers of two, shared factors and full-range values.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
design/lbg_pkg.sv
design/lbg_if.sv
design/lbg_datapath.sv
design/lcm_binary_gcd_unit.sv
design/lbg_chk.sv
tb/lbg_result_checker.sv
tb/testbench.sv
